@@ rtl/sflt_pkg.sv @@
package sflt_pkg;

    // Table size and the widths that follow from it
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths
    localparam int STEP_W = 16;
    localparam int TIME_W = 32;
    localparam int PAY_W  = 16;
    localparam int KEY_W  = 32;
    localparam int OIDX_W = 8;
    localparam int OCNT_W = 9;

    typedef enum logic [1:0] {
        ACT_INSERT      = 2'd0,
        ACT_STEP_LOOKUP = 2'd1,
        ACT_TIME_LOOKUP = 2'd2,
        ACT_READ_INDEX  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BEFORE_FIRST = 2'd1,
        ST_FULL         = 2'd2,
        ST_RANGE        = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_FETCH,
        S_RESULT
    } state_t;

    // One table entry as it travels along the ring
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [TIME_W-1:0] stamp;
        logic [PAY_W-1:0]  handle;
    } entry_t;

    // Ring control from the sequencer to the cells
    typedef struct packed {
        logic   shift;
        entry_t inject;
    } ring_ctl_t;

endpackage

@@ rtl/sflt_cell.sv @@
module sflt_cell
    import sflt_pkg::*;
(
    input  logic   clk,
    input  logic   shift,
    input  entry_t entry_in,
    output entry_t entry_q
);

    entry_t entry_reg;

    // Take the neighbor's entry on every ring step
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= entry_in;
        end
    end

    assign entry_q = entry_reg;

endmodule

@@ rtl/sflt_ctrl.sv @@
module sflt_ctrl
    import sflt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [STEP_W-1:0] step_num,
    input  logic [TIME_W-1:0] time_sec,
    input  logic [PAY_W-1:0]  payload_handle,
    input  logic [7:0]        entry_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [OIDX_W-1:0] found_index,
    output logic [STEP_W-1:0] step_out,
    output logic [TIME_W-1:0] time_out,
    output logic [PAY_W-1:0]  payload_out,
    output logic              replaced,
    output logic [OCNT_W-1:0] entry_count,
    input  entry_t            head,
    output ring_ctl_t         ring
);

    state_t state_reg, state_next;

    action_t            op_reg;
    entry_t             new_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [STEP_W-1:0]  least_step_reg, greatest_step_reg;
    logic [TIME_W-1:0]  least_time_reg, greatest_time_reg;
    logic               found_reg, reject_reg, rep_reg, shifting_reg;
    logic [IDX_W-1:0]   pos_reg;
    entry_t             carry_reg;
    logic [CNT_W-1:0]   hits_reg;
    logic [IDX_W-1:0]   target_reg;
    status_t            res_status_reg;
    logic [IDX_W-1:0]   res_index_reg;
    entry_t             res_entry_reg;
    logic               res_rep_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [OIDX_W-1:0]  out_index_reg;
    entry_t             out_entry_reg;
    logic               out_rep_reg;
    logic [OCNT_W-1:0]  out_count_reg;

    action_t            in_act;
    logic [KEY_W-1:0]   in_key, in_lo, in_hi;
    logic               early_err, at_top, idx_bad;
    status_t            in_status;
    logic [IDX_W-1:0]   in_target;
    logic [CNT_W-1:0]   k_ext;
    logic               k_live, at_end, last, full, out_free, accept, load_out;
    logic               ev_rep, ev_reject, ev_open, ev_append, ev_close, hit;
    logic [KEY_W-1:0]   head_val;
    entry_t             inject;

    // Decode the arriving item
    always_comb
    begin
        in_act    = action_t'(action);
        in_key    = (in_act == ACT_STEP_LOOKUP) ? KEY_W'(step_num) : time_sec;
        in_lo     = (in_act == ACT_STEP_LOOKUP) ? KEY_W'(least_step_reg) : least_time_reg;
        in_hi     = (in_act == ACT_STEP_LOOKUP) ? KEY_W'(greatest_step_reg) : greatest_time_reg;
        early_err = (count_reg == '0) || (in_key < in_lo);
        at_top    = (in_key >= in_hi);
        idx_bad   = (32'(entry_index) >= 32'(count_reg));
        in_status = ST_OK;
        in_target = IDX_W'(count_reg - CNT_W'(1));
        unique case (in_act)
            ACT_STEP_LOOKUP, ACT_TIME_LOOKUP:
            begin
                if (early_err)
                    in_status = ST_BEFORE_FIRST;
            end
            ACT_READ_INDEX:
            begin
                if (idx_bad)
                    in_status = ST_RANGE;
                in_target = IDX_W'(entry_index);
            end
            default:
            begin
            end
        endcase
    end

    assign k_ext    = CNT_W'(k_reg);
    assign k_live   = (k_ext < count_reg);
    assign at_end   = (k_ext == count_reg);
    assign last     = (k_reg == IDX_W'(TABLE_DEPTH - 1));
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = (state_reg == S_IDLE) && in_valid;
    assign load_out = (state_reg == S_RESULT) && out_free;
    assign head_val = (op_reg == ACT_STEP_LOOKUP) ? KEY_W'(head.step) : head.stamp;

    // Decide what re-enters the ring while entries pass the head
    always_comb
    begin
        inject    = head;
        ev_rep    = 1'b0;
        ev_reject = 1'b0;
        ev_open   = 1'b0;
        ev_append = 1'b0;
        ev_close  = 1'b0;
        if (state_reg == S_SCAN && op_reg == ACT_INSERT)
        begin
            if (!found_reg)
            begin
                if (k_live && head.step >= new_reg.step)
                begin
                    if (head.step == new_reg.step)
                    begin
                        ev_rep = 1'b1;
                        inject = new_reg;
                    end
                    else if (full)
                    begin
                        ev_reject = 1'b1;
                    end
                    else
                    begin
                        ev_open = 1'b1;
                        inject  = new_reg;
                    end
                end
                else if (at_end)
                begin
                    ev_append = 1'b1;
                    inject    = new_reg;
                end
            end
            else if (shifting_reg && (k_live || at_end))
            begin
                inject   = carry_reg;
                ev_close = at_end;
            end
        end
    end

    assign hit = (state_reg == S_SCAN) && (op_reg != ACT_INSERT) && k_live
                 && (head_val <= key_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_act)
                        ACT_INSERT:
                            state_next = S_SCAN;
                        ACT_STEP_LOOKUP, ACT_TIME_LOOKUP:
                            state_next = early_err ? S_RESULT : (at_top ? S_FETCH : S_SCAN);
                        ACT_READ_INDEX:
                            state_next = idx_bad ? S_RESULT : S_FETCH;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
                state_next = last ? S_COMMIT : S_SCAN;
            S_COMMIT:
                state_next = (op_reg == ACT_INSERT) ? S_RESULT : S_FETCH;
            S_FETCH:
                state_next = last ? S_RESULT : S_FETCH;
            S_RESULT:
                state_next = out_free ? S_IDLE : S_RESULT;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Handshake and ring control
    always_comb
    begin
        in_stall     = (state_reg != S_IDLE);
        ring.shift   = (state_reg == S_SCAN) || (state_reg == S_FETCH);
        ring.inject  = inject;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Table bookkeeping: count, running extremes, ring position and per-item scan flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            least_step_reg    <= '0;
            greatest_step_reg <= '0;
            least_time_reg    <= '0;
            greatest_time_reg <= '0;
            k_reg             <= '0;
            found_reg         <= 1'b0;
            reject_reg        <= 1'b0;
            rep_reg           <= 1'b0;
            shifting_reg      <= 1'b0;
            hits_reg          <= '0;
        end
        else
        begin
            if (accept)
            begin
                found_reg    <= 1'b0;
                reject_reg   <= 1'b0;
                rep_reg      <= 1'b0;
                shifting_reg <= 1'b0;
                hits_reg     <= '0;
            end
            // Advance the ring position over one full revolution
            if (ring.shift)
            begin
                k_reg <= last ? '0 : k_reg + IDX_W'(1);
            end
            if (ev_rep)
            begin
                found_reg <= 1'b1;
                rep_reg   <= 1'b1;
            end
            if (ev_reject)
            begin
                found_reg  <= 1'b1;
                reject_reg <= 1'b1;
            end
            if (ev_open)
            begin
                found_reg    <= 1'b1;
                shifting_reg <= 1'b1;
            end
            if (ev_append)
            begin
                found_reg <= 1'b1;
            end
            if (ev_close)
            begin
                shifting_reg <= 1'b0;
            end
            if (hit)
            begin
                hits_reg <= hits_reg + CNT_W'(1);
            end
            // Commit a successful insert
            if (state_reg == S_COMMIT && op_reg == ACT_INSERT && found_reg && !reject_reg)
            begin
                if (!rep_reg)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (!rep_reg && count_reg == '0)
                begin
                    least_step_reg    <= new_reg.step;
                    greatest_step_reg <= new_reg.step;
                    least_time_reg    <= new_reg.stamp;
                    greatest_time_reg <= new_reg.stamp;
                end
                else
                begin
                    if (new_reg.step < least_step_reg)
                        least_step_reg <= new_reg.step;
                    if (new_reg.step > greatest_step_reg)
                        greatest_step_reg <= new_reg.step;
                    if (new_reg.stamp < least_time_reg)
                        least_time_reg <= new_reg.stamp;
                    if (new_reg.stamp > greatest_time_reg)
                        greatest_time_reg <= new_reg.stamp;
                end
            end
        end
    end

    // Item operands and the result under construction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= in_act;
            new_reg.step   <= step_num;
            new_reg.stamp  <= time_sec;
            new_reg.handle <= payload_handle;
            key_reg        <= in_key;
            res_status_reg <= in_status;
            res_index_reg  <= '0;
            res_entry_reg  <= '0;
            res_rep_reg    <= 1'b0;
            target_reg     <= in_target;
        end
        if (ev_rep || ev_open || ev_append)
        begin
            pos_reg <= k_reg;
        end
        // Hold the displaced entry one slot behind
        if (ev_open || (state_reg == S_SCAN && op_reg == ACT_INSERT && shifting_reg && k_live))
        begin
            carry_reg <= head;
        end
        if (state_reg == S_COMMIT)
        begin
            if (op_reg == ACT_INSERT)
            begin
                if (!found_reg || reject_reg)
                begin
                    res_status_reg <= ST_FULL;
                end
                else
                begin
                    res_index_reg <= pos_reg;
                    res_entry_reg <= new_reg;
                    res_rep_reg   <= rep_reg;
                end
            end
            else
            begin
                target_reg <= (hits_reg != '0) ? IDX_W'(hits_reg - CNT_W'(1)) : '0;
            end
        end
        // Capture the selected entry as it passes the head
        if (state_reg == S_FETCH && k_reg == target_reg)
        begin
            res_entry_reg <= head;
            res_index_reg <= target_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= OIDX_W'(res_index_reg);
            out_entry_reg  <= res_entry_reg;
            out_rep_reg    <= res_rep_reg;
            out_count_reg  <= OCNT_W'(count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_index = out_index_reg;
    assign step_out    = out_entry_reg.step;
    assign time_out    = out_entry_reg.stamp;
    assign payload_out = out_entry_reg.handle;
    assign replaced    = out_rep_reg;
    assign entry_count = out_count_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> k_reg == '0)
        else $error("ring not aligned while idle");

    a_count_commit_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_COMMIT |=> $stable(count_reg))
        else $error("count changed outside commit");

    a_no_shift_full: assert property (@(posedge clk) disable iff (!rst_n)
        shifting_reg |-> !full)
        else $error("shifting insert on a full table");

    a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_OK |->
        out_index_reg == '0 && out_entry_reg == '0 && !out_rep_reg)
        else $error("error result carries entry data");

endmodule

@@ rtl/sorted_floor_lookup_table_core.sv @@
// Channel | Handshake           | Fields
// input   | in_valid / in_stall  | action, step_num, time_sec, payload_handle, entry_index
// output  | out_valid / out_stall| status, found_index, step_out, time_out, payload_out,
//         |                      | replaced, entry_count
//
// The table lives in a ring of TABLE_DEPTH cells; operations rotate it in full
// revolutions past the head cell, where the sequencer reads and re-injects entries.
// Insert: one scan pass, then commit. Read by index and lookups at or above the greatest
// key: one fetch pass. Other floor lookups: a count pass, then a fetch pass. Errors
// found on arrival skip the ring. One item is in flight at a time.
// Reset clears the count and extremes; cell contents are undefined until written.
// A new item is taken while a result waits in the output register.
module sorted_floor_lookup_table_core
    import sflt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [STEP_W-1:0] step_num,
    input  logic [TIME_W-1:0] time_sec,
    input  logic [PAY_W-1:0]  payload_handle,
    input  logic [7:0]        entry_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [OIDX_W-1:0] found_index,
    output logic [STEP_W-1:0] step_out,
    output logic [TIME_W-1:0] time_out,
    output logic [PAY_W-1:0]  payload_out,
    output logic              replaced,
    output logic [OCNT_W-1:0] entry_count
);

    ring_ctl_t ring;
    entry_t    cell_q [TABLE_DEPTH];

    sflt_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .step_num       (step_num),
        .time_sec       (time_sec),
        .payload_handle (payload_handle),
        .entry_index    (entry_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_index    (found_index),
        .step_out       (step_out),
        .time_out       (time_out),
        .payload_out    (payload_out),
        .replaced       (replaced),
        .entry_count    (entry_count),
        .head           (cell_q[0]),
        .ring           (ring)
    );

    // Build the ring: each cell takes from the one above, the top cell from the sequencer
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t link;
        if (i == TABLE_DEPTH - 1)
        begin : g_top
            assign link = ring.inject;
        end
        else
        begin : g_mid
            assign link = cell_q[i + 1];
        end
        sflt_cell u_cell (
            .clk      (clk),
            .shift    (ring.shift),
            .entry_in (link),
            .entry_q  (cell_q[i])
        );
    end

endmodule

@@ test/sorted_floor_lookup_table_core_tb.sv @@
module sorted_floor_lookup_table_core_tb
    import sflt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // One request to the table and one reply from it
    typedef struct packed {
        action_t           act;
        logic [STEP_W-1:0] step;
        logic [TIME_W-1:0] stamp;
        logic [PAY_W-1:0]  handle;
        logic [7:0]        index;
    } table_op_t;

    typedef struct packed {
        status_t           status;
        logic [OIDX_W-1:0] index;
        logic [STEP_W-1:0] step;
        logic [TIME_W-1:0] stamp;
        logic [PAY_W-1:0]  handle;
        logic              replaced;
        logic [OCNT_W-1:0] count;
    } table_reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        action = ACT_INSERT;
    logic [STEP_W-1:0] step_num = '0;
    logic [TIME_W-1:0] time_sec = '0;
    logic [PAY_W-1:0]  payload_handle = '0;
    logic [7:0]        entry_index = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        status;
    logic [OIDX_W-1:0] found_index;
    logic [STEP_W-1:0] step_out;
    logic [TIME_W-1:0] time_out;
    logic [PAY_W-1:0]  payload_out;
    logic              replaced;
    logic [OCNT_W-1:0] entry_count;

    // Shadow copy of the table and its running extremes
    logic [STEP_W-1:0] shadow_step   [TABLE_DEPTH];
    logic [TIME_W-1:0] shadow_stamp  [TABLE_DEPTH];
    logic [PAY_W-1:0]  shadow_handle [TABLE_DEPTH];
    int                shadow_count = 0;
    logic [STEP_W-1:0] low_step = '0;
    logic [STEP_W-1:0] high_step = '0;
    logic [TIME_W-1:0] low_stamp = '0;
    logic [TIME_W-1:0] high_stamp = '0;

    table_reply_t expected_replies[$];
    int           mismatch_count = 0;
    bit           sender_idle = 1'b1;
    bit           receiver_idle = 1'b1;
    int           holdoff_request = 0;

    sorted_floor_lookup_table_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .step_num       (step_num),
        .time_sec       (time_sec),
        .payload_handle (payload_handle),
        .entry_index    (entry_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_index    (found_index),
        .step_out       (step_out),
        .time_out       (time_out),
        .payload_out    (payload_out),
        .replaced       (replaced),
        .entry_count    (entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reply carrying the entry at a position
    function automatic table_reply_t entry_reply(int pos, logic rep);
        table_reply_t r;
        r          = '0;
        r.status   = ST_OK;
        r.index    = pos[OIDX_W-1:0];
        r.step     = shadow_step[pos];
        r.stamp    = shadow_stamp[pos];
        r.handle   = shadow_handle[pos];
        r.replaced = rep;
        r.count    = shadow_count[OCNT_W-1:0];
        return r;
    endfunction

    function automatic table_reply_t error_reply(status_t st);
        table_reply_t r;
        r        = '0;
        r.status = st;
        r.count  = shadow_count[OCNT_W-1:0];
        return r;
    endfunction

    // Floor search over steps or times: last entry at or below the key
    function automatic table_reply_t floor_search(bit by_step, logic [31:0] key);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] v;
        int          n;
        int          pos;
        lo = by_step ? {16'h0, low_step} : low_stamp;
        hi = by_step ? {16'h0, high_step} : high_stamp;
        if (shadow_count == 0 || key < lo)
            return error_reply(ST_BEFORE_FIRST);
        if (key >= hi)
        begin
            pos = shadow_count - 1;
        end
        else
        begin
            n = 0;
            for (int i = 0; i < shadow_count; i++)
            begin
                v = by_step ? {16'h0, shadow_step[i]} : shadow_stamp[i];
                if (v <= key)
                    n++;
            end
            pos = (n > 0) ? n - 1 : 0;
        end
        return entry_reply(pos, 1'b0);
    endfunction

    // Append, replace or insert in step order; reject growth of a full table
    function automatic table_reply_t insert_entry(logic [STEP_W-1:0] stp,
                                                  logic [TIME_W-1:0] stm,
                                                  logic [PAY_W-1:0] hdl);
        int   pos;
        logic rep;
        pos = 0;
        rep = 1'b0;
        if (shadow_count == 0 || stp > high_step)
        begin
            pos = shadow_count;
        end
        else
        begin
            for (int i = 0; i < shadow_count; i++)
                if (shadow_step[i] < stp)
                    pos++;
            if (pos < shadow_count && shadow_step[pos] == stp)
                rep = 1'b1;
        end
        if (!rep && shadow_count >= TABLE_DEPTH)
            return error_reply(ST_FULL);
        if (!rep)
        begin
            for (int i = shadow_count; i > pos; i--)
            begin
                shadow_step[i]   = shadow_step[i-1];
                shadow_stamp[i]  = shadow_stamp[i-1];
                shadow_handle[i] = shadow_handle[i-1];
            end
            shadow_count++;
        end
        shadow_step[pos]   = stp;
        shadow_stamp[pos]  = stm;
        shadow_handle[pos] = hdl;
        if (shadow_count == 1 && !rep)
        begin
            low_step   = stp;
            high_step  = stp;
            low_stamp  = stm;
            high_stamp = stm;
        end
        else
        begin
            if (stp < low_step)   low_step   = stp;
            if (stp > high_step)  high_step  = stp;
            if (stm < low_stamp)  low_stamp  = stm;
            if (stm > high_stamp) high_stamp = stm;
        end
        return entry_reply(pos, rep);
    endfunction

    // Advance the shadow table by one request and return its reply
    function automatic table_reply_t apply_op(table_op_t op);
        unique case (op.act)
            ACT_INSERT:      return insert_entry(op.step, op.stamp, op.handle);
            ACT_STEP_LOOKUP: return floor_search(1'b1, {16'h0, op.step});
            ACT_TIME_LOOKUP: return floor_search(1'b0, op.stamp);
            default:
                if (op.index >= shadow_count)
                    return error_reply(ST_RANGE);
                else
                    return entry_reply(op.index, 1'b0);
        endcase
    endfunction

    // Random request; steps stay in 0..step_span most of the time when span > 0
    function automatic table_op_t random_op(int step_span);
        table_op_t op;
        int        pick;
        op.act    = action_t'($urandom_range(0, 3));
        op.step   = (step_span > 0 && $urandom_range(0, 9) != 0) ?
                    STEP_W'($urandom_range(0, step_span)) : STEP_W'($urandom);
        op.stamp  = $urandom;
        op.handle = PAY_W'($urandom);
        op.index  = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(0, shadow_count + 2));
        // aim at stored keys so that exact hits and replacements are common
        if (shadow_count > 0 && $urandom_range(0, 2) == 0)
        begin
            pick     = $urandom_range(0, shadow_count - 1);
            op.step  = shadow_step[pick];
            op.stamp = shadow_stamp[pick] + TIME_W'($urandom_range(0, 2)) - 32'd1;
        end
        return op;
    endfunction

    // Offer one request and hold it until the transfer
    task automatic send_op(input table_op_t op);
        if (sender_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        action         <= op.act;
        step_num       <= op.step;
        time_sec       <= op.stamp;
        payload_handle <= op.handle;
        entry_index    <= op.index;
        do @(posedge clk); while (in_stall !== 1'b0);
        expected_replies.push_back(apply_op(op));
    endtask

    task automatic send_fields(input action_t act, input logic [STEP_W-1:0] stp,
                               input logic [TIME_W-1:0] stm, input logic [PAY_W-1:0] hdl,
                               input logic [7:0] idx);
        table_op_t op;
        op.act    = act;
        op.step   = stp;
        op.stamp  = stm;
        op.handle = hdl;
        op.index  = idx;
        send_op(op);
    endtask

    // Drop valid and wait for every outstanding reply
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_replies.size() != 0);
    endtask

    task automatic send_random(int n, int step_span);
        repeat (n) send_op(random_op(step_span));
    endtask

    task automatic test_empty_table();
        send_fields(ACT_STEP_LOOKUP, 16'h0000, 32'h0, 16'h0, 8'h00);
        send_fields(ACT_TIME_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_fields(ACT_READ_INDEX, 16'h0, 32'h0, 16'h0, 8'h00);
        send_fields(ACT_READ_INDEX, 16'h0, 32'h0, 16'h0, 8'hFF);
    endtask

    task automatic test_insert_and_lookup();
        // first insert, append with an earlier time, middle insert, replace
        send_fields(ACT_INSERT, 16'd100, 32'd1000, 16'h0000, 8'h00);
        send_fields(ACT_INSERT, 16'd200, 32'd500, 16'hFFFF, 8'h00);
        send_fields(ACT_INSERT, 16'd150, 32'd2000, 16'h1234, 8'h00);
        send_fields(ACT_INSERT, 16'd150, 32'd3000, 16'h5678, 8'h00);
        // step lookups: before the first, exact, between entries
        send_fields(ACT_STEP_LOOKUP, 16'd99, 32'h0, 16'h0, 8'h00);
        send_fields(ACT_STEP_LOOKUP, 16'd150, 32'h0, 16'h0, 8'h00);
        send_fields(ACT_STEP_LOOKUP, 16'd175, 32'h0, 16'h0, 8'h00);
        // time lookups while times do not rise with steps
        send_fields(ACT_TIME_LOOKUP, 16'h0, 32'd700, 16'h0, 8'h00);
        send_fields(ACT_TIME_LOOKUP, 16'h0, 32'd400, 16'h0, 8'h00);
        // replace the front entry so the least time goes stale
        send_fields(ACT_INSERT, 16'd50, 32'd0, 16'h00FF, 8'h00);
        send_fields(ACT_INSERT, 16'd50, 32'd4000, 16'hFF00, 8'h00);
        send_fields(ACT_TIME_LOOKUP, 16'h0, 32'd1, 16'h0, 8'h00);
        // field extremes at both ends of the table
        send_fields(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'hAAAA, 8'hFF);
        send_fields(ACT_INSERT, 16'h0000, 32'h8000_0000, 16'h5555, 8'h00);
        send_fields(ACT_STEP_LOOKUP, 16'hFFFF, 32'h0, 16'h0, 8'h00);
        send_fields(ACT_TIME_LOOKUP, 16'h0, 32'hFFFF_FFFF, 16'h0, 8'h00);
        // read by index: first, last, one past the end
        send_fields(ACT_READ_INDEX, 16'h0, 32'h0, 16'h0, 8'd0);
        send_fields(ACT_READ_INDEX, 16'h0, 32'h0, 16'h0, 8'(shadow_count - 1));
        send_fields(ACT_READ_INDEX, 16'h0, 32'h0, 16'h0, 8'(shadow_count));
    endtask

    task automatic test_random_dense_steps();
        send_random(500, 300);
    endtask

    task automatic test_sender_pause();
        send_random(15, 300);
        wait_drained();
        send_random(15, 300);
    endtask

    // Hold the output long enough that the block backs up and stalls its input
    task automatic test_receiver_holdoff();
        holdoff_request = 3000;
        send_random(6, 300);
        wait_drained();
    endtask

    task automatic test_fill_table();
        table_op_t op;
        while (shadow_count < TABLE_DEPTH)
        begin
            op = random_op(0);
            if ($urandom_range(0, 3) != 0)
                op.act = ACT_INSERT;
            send_op(op);
        end
    endtask

    task automatic test_full_table();
        logic [STEP_W-1:0] fresh;
        bit                taken;
        int                pick;
        // a new step is rejected, an equal step still replaces
        do
        begin
            fresh = STEP_W'($urandom);
            taken = 1'b0;
            for (int i = 0; i < shadow_count; i++)
                if (shadow_step[i] == fresh)
                    taken = 1'b1;
        end
        while (taken);
        send_fields(ACT_INSERT, fresh, $urandom, 16'h0F0F, 8'h00);
        pick = $urandom_range(0, shadow_count - 1);
        send_fields(ACT_INSERT, shadow_step[pick], $urandom, 16'hF0F0, 8'h00);
        send_fields(ACT_READ_INDEX, 16'h0, 32'h0, 16'h0, 8'hFF);
        send_random(300, 0);
    endtask

    task automatic test_back_to_back();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        send_random(150, 0);
    endtask

    // Check each reply transfer against the oldest expectation; drive out_stall
    initial
    begin : reply_sink
        int           stall_left;
        table_reply_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("reply with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatch_count++;
                    end
                    if (found_index !== want.index)
                    begin
                        $error("found_index: expected %0d, actual %0d", want.index, found_index);
                        mismatch_count++;
                    end
                    if (step_out !== want.step)
                    begin
                        $error("step_out: expected %0d, actual %0d", want.step, step_out);
                        mismatch_count++;
                    end
                    if (time_out !== want.stamp)
                    begin
                        $error("time_out: expected %0d, actual %0d", want.stamp, time_out);
                        mismatch_count++;
                    end
                    if (payload_out !== want.handle)
                    begin
                        $error("payload_out: expected %0d, actual %0d", want.handle, payload_out);
                        mismatch_count++;
                    end
                    if (replaced !== want.replaced)
                    begin
                        $error("replaced: expected %0d, actual %0d", want.replaced, replaced);
                        mismatch_count++;
                    end
                    if (entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
                        mismatch_count++;
                    end
                end
            end
            // pick the stall for the next cycle: long hold-off, random burst or none
            if (holdoff_request > 0)
            begin
                stall_left      = holdoff_request;
                holdoff_request = 0;
            end
            else if (stall_left == 0 && receiver_idle && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 11);
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_insert_and_lookup();
        test_random_dense_steps();
        test_sender_pause();
        test_receiver_holdoff();
        test_fill_table();
        test_full_table();
        test_back_to_back();
        wait_drained();
        repeat (600) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
